// ===== sv/stt_pkg.sv =====
// Shared types, codes and character classes for the score text tokenizer.
package stt_pkg;

  localparam int unsigned KindW = 5;
  localparam int unsigned ErrW  = 3;
  localparam int unsigned LineW = 16;
  localparam int unsigned LenW  = 12;

  localparam logic [LineW-1:0] LineMax = '1;
  localparam logic [LenW-1:0]  LenMax  = '1;

  typedef enum logic [22:0] {
    M_IDLE      = 23'd1 << 0,
    M_BLANK     = 23'd1 << 1,
    M_SLASH     = 23'd1 << 2,
    M_BC        = 23'd1 << 3,
    M_BC_STAR   = 23'd1 << 4,
    M_PCT       = 23'd1 << 5,
    M_PB        = 23'd1 << 6,
    M_PB_PCT    = 23'd1 << 7,
    M_LINE      = 23'd1 << 8,
    M_COLON     = 23'd1 << 9,
    M_COLON_BAR = 23'd1 << 10,
    M_BANG      = 23'd1 << 11,
    M_BAR       = 23'd1 << 12,
    M_SQ        = 23'd1 << 13,
    M_SQ_ESC    = 23'd1 << 14,
    M_DQ        = 23'd1 << 15,
    M_DQ_ESC    = 23'd1 << 16,
    M_IDENT     = 23'd1 << 17,
    M_INT       = 23'd1 << 18,
    M_DOT       = 23'd1 << 19,
    M_FRAC      = 23'd1 << 20,
    M_EXP       = 23'd1 << 21,
    M_EXPD      = 23'd1 << 22
  } mode_t;

  // token kinds
  localparam logic [KindW-1:0] TK_BLANK   = 5'd0;
  localparam logic [KindW-1:0] TK_NL      = 5'd1;
  localparam logic [KindW-1:0] TK_BCMT    = 5'd2;
  localparam logic [KindW-1:0] TK_LCMT    = 5'd3;
  localparam logic [KindW-1:0] TK_SLASH   = 5'd4;
  localparam logic [KindW-1:0] TK_EQ      = 5'd5;
  localparam logic [KindW-1:0] TK_COMMA   = 5'd6;
  localparam logic [KindW-1:0] TK_COLON   = 5'd7;
  localparam logic [KindW-1:0] TK_REPEAT  = 5'd8;
  localparam logic [KindW-1:0] TK_SEMI    = 5'd9;
  localparam logic [KindW-1:0] TK_PLUS    = 5'd10;
  localparam logic [KindW-1:0] TK_MINUS   = 5'd11;
  localparam logic [KindW-1:0] TK_STAR    = 5'd12;
  localparam logic [KindW-1:0] TK_BANG2   = 5'd13;
  localparam logic [KindW-1:0] TK_QUEST   = 5'd14;
  localparam logic [KindW-1:0] TK_LPAR    = 5'd15;
  localparam logic [KindW-1:0] TK_RPAR    = 5'd16;
  localparam logic [KindW-1:0] TK_LBRACE  = 5'd17;
  localparam logic [KindW-1:0] TK_RBRACE  = 5'd18;
  localparam logic [KindW-1:0] TK_DOT     = 5'd19;
  localparam logic [KindW-1:0] TK_BAR     = 5'd20;
  localparam logic [KindW-1:0] TK_BAR2    = 5'd21;
  localparam logic [KindW-1:0] TK_INT     = 5'd22;
  localparam logic [KindW-1:0] TK_DEC     = 5'd23;
  localparam logic [KindW-1:0] TK_SQSTR   = 5'd24;
  localparam logic [KindW-1:0] TK_DQSTR   = 5'd25;
  localparam logic [KindW-1:0] TK_IDENT   = 5'd26;
  localparam logic [KindW-1:0] TK_ILLEGAL = 5'd27;

  // error codes
  localparam logic [ErrW-1:0] ER_NONE    = 3'd0;
  localparam logic [ErrW-1:0] ER_ILLEGAL = 3'd1;
  localparam logic [ErrW-1:0] ER_REPEAT  = 3'd2;
  localparam logic [ErrW-1:0] ER_FRAC    = 3'd3;
  localparam logic [ErrW-1:0] ER_EXP     = 3'd4;
  localparam logic [ErrW-1:0] ER_ESCAPE  = 3'd5;
  localparam logic [ErrW-1:0] ER_UNTERM  = 3'd6;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_UPE    = 8'h45;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOE    = 8'h65;
  localparam logic [7:0] CH_LON    = 8'h6E;
  localparam logic [7:0] CH_LOT    = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [LineW-1:0] line;
    logic [ErrW-1:0]  err;
    logic [KindW-1:0] kind;
    logic             last;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_CR};
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return c inside {CH_LOE, CH_UPE};
  endfunction

  function automatic logic [LenW-1:0] len_inc(input logic [LenW-1:0] l);
    return (l == LenMax) ? l : LenW'(l + 1'b1);
  endfunction

endpackage

// ===== sv/score_text_tokenizer.sv =====
// Score text tokenizer: one character in per transfer, tokens out through a result queue.
//
// Input stream: in_tdata carries one source byte, in_tlast marks the final byte of
// the text; the pending token is flushed on it and the lexer returns to idle.
// Output stream: one token per transfer; out_tlast is set on the last token caused
// by one input byte (a byte causes zero, one or two tokens).
// The lexer state (mode, line, token length, pending error) is updated in the
// cycle the byte is taken; its tokens are written to a four-entry result queue
// and show on out_tvalid from the next cycle on.
// Throughput: one byte per cycle while the queue has room for two tokens
// (in_tready is driven from the queue fill only). A byte that causes two tokens
// always leaves the lexer idle, so the next byte causes at most one; with the
// receiver always ready the queue never holds more than two tokens and the input
// takes one byte every cycle.
// Reset: lexer idle, line counter 1, queue empty.
// A stalled receiver holds the head token; the queue fills and in_tready drops
// until two places are free again.
module score_text_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] token_kind, [7:5] error_kind,
                                  // [23:8] line_number, [35:24] token_length
  output logic        out_tlast   // last_of_run
);
  import stt_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [LineW-1:0] line_r, line_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic [ErrW-1:0]  err_r, err_nxt;

  res_t             q_r [4];
  logic [1:0]       rd_ptr_r, wr_ptr_r;
  logic [2:0]       count_r, count_nxt;

  logic [7:0]       c;
  logic             acc, pop;
  logic [LenW-1:0]  inc;

  mode_t            fm;
  logic [LenW-1:0]  fl;
  logic [ErrW-1:0]  fe;
  logic             bump, do_start;
  logic             f_emit, s_emit, x_emit;
  logic [KindW-1:0] f_kind, s_kind, x_kind;
  logic [ErrW-1:0]  f_err, s_err, x_err;
  logic [LenW-1:0]  f_len;
  logic [LineW-1:0] line_b;
  res_t             rf, rs, rx, r0, r1;
  logic             n1, n2;

  assign c   = in_tdata;
  assign acc = in_tvalid && in_tready;
  assign pop = out_tvalid && out_tready;
  assign inc = len_inc(len_r);

  // feed the byte to the current mode
  always_comb begin
    fm       = mode_r;
    fl       = len_r;
    fe       = err_r;
    bump     = 1'b0;
    do_start = 1'b0;
    f_emit   = 1'b0;
    f_kind   = TK_BLANK;
    f_err    = ER_NONE;
    f_len    = len_r;
    s_emit   = 1'b0;
    s_kind   = TK_BLANK;
    s_err    = ER_NONE;
    case (mode_r)
      M_BLANK: begin
        if (is_blank(c)) fl = inc;
        else begin f_emit = 1'b1; f_kind = TK_BLANK; do_start = 1'b1; end
      end
      M_SLASH: begin
        if (c == CH_STAR) begin fl = inc; fm = M_BC; end
        else begin f_emit = 1'b1; f_kind = TK_SLASH; do_start = 1'b1; end
      end
      M_BC: begin
        fl = inc;
        if (c == CH_NL) bump = 1'b1;
        else if (c == CH_STAR) fm = M_BC_STAR;
      end
      M_BC_STAR: begin
        fl = inc;
        if (c == CH_SLASH) begin f_emit = 1'b1; f_kind = TK_BCMT; f_len = inc; end
        else if (c != CH_STAR) begin bump = (c == CH_NL); fm = M_BC; end
      end
      M_PCT: begin
        if (c == CH_LBRACE) begin fl = inc; fm = M_PB; end
        else if (c == CH_NL) begin f_emit = 1'b1; f_kind = TK_LCMT; do_start = 1'b1; end
        else begin fl = inc; fm = M_LINE; end
      end
      M_PB: begin
        fl = inc;
        if (c == CH_NL) bump = 1'b1;
        else if (c == CH_PCT) fm = M_PB_PCT;
      end
      M_PB_PCT: begin
        fl = inc;
        if (c == CH_RBRACE) begin f_emit = 1'b1; f_kind = TK_BCMT; f_len = inc; end
        else if (c != CH_PCT) begin bump = (c == CH_NL); fm = M_PB; end
      end
      M_LINE: begin
        if (c == CH_NL) begin f_emit = 1'b1; f_kind = TK_LCMT; do_start = 1'b1; end
        else fl = inc;
      end
      M_COLON: begin
        if (c == CH_BAR) begin fl = inc; fm = M_COLON_BAR; end
        else begin f_emit = 1'b1; f_kind = TK_COLON; do_start = 1'b1; end
      end
      M_COLON_BAR: begin
        f_emit = 1'b1;
        if (c == CH_BAR) begin f_kind = TK_REPEAT; f_len = inc; end
        else begin f_kind = TK_ILLEGAL; f_err = ER_REPEAT; do_start = 1'b1; end
      end
      M_BANG: begin
        f_emit = 1'b1;
        if (c == CH_BANG) begin f_kind = TK_BANG2; f_len = inc; end
        else begin f_kind = TK_ILLEGAL; f_err = ER_ILLEGAL; do_start = 1'b1; end
      end
      M_BAR: begin
        f_emit = 1'b1;
        if (c == CH_BAR) begin f_kind = TK_BAR2; f_len = inc; end
        else begin f_kind = TK_BAR; do_start = 1'b1; end
      end
      M_SQ, M_DQ: begin
        fl = inc;
        if ((mode_r == M_SQ && c == CH_SQUOTE) || (mode_r == M_DQ && c == CH_DQUOTE)) begin
          f_emit = 1'b1;
          f_kind = (mode_r == M_SQ) ? TK_SQSTR : TK_DQSTR;
          f_err  = err_r;
          f_len  = inc;
        end else if (c == CH_BSLASH) fm = (mode_r == M_SQ) ? M_SQ_ESC : M_DQ_ESC;
        else if (c == CH_NL) bump = 1'b1;
      end
      M_SQ_ESC, M_DQ_ESC: begin
        fl = inc;
        fm = (mode_r == M_SQ_ESC) ? M_SQ : M_DQ;
        if (!(c inside {CH_DQUOTE, CH_BSLASH, CH_LON, CH_LOT})) begin
          // bad escape: flag it and treat the byte as a string byte
          fe = ER_ESCAPE;
          if ((mode_r == M_SQ_ESC && c == CH_SQUOTE) ||
              (mode_r == M_DQ_ESC && c == CH_DQUOTE)) begin
            f_emit = 1'b1;
            f_kind = (mode_r == M_SQ_ESC) ? TK_SQSTR : TK_DQSTR;
            f_err  = ER_ESCAPE;
            f_len  = inc;
          end else if (c == CH_BSLASH) fm = mode_r;
          else if (c == CH_NL) bump = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == CH_UNDER) fl = inc;
        else begin f_emit = 1'b1; f_kind = TK_IDENT; do_start = 1'b1; end
      end
      M_INT: begin
        if (is_digit(c)) fl = inc;
        else if (c == CH_DOT) begin fl = inc; fm = M_DOT; end
        else if (is_exp(c)) begin fl = inc; fm = M_EXP; end
        else begin f_emit = 1'b1; f_kind = TK_INT; do_start = 1'b1; end
      end
      M_DOT: begin
        if (is_digit(c)) begin fl = inc; fm = M_FRAC; end
        else begin f_emit = 1'b1; f_kind = TK_DEC; f_err = ER_FRAC; do_start = 1'b1; end
      end
      M_FRAC: begin
        if (is_digit(c)) fl = inc;
        else if (is_exp(c)) begin fl = inc; fm = M_EXP; end
        else begin f_emit = 1'b1; f_kind = TK_DEC; do_start = 1'b1; end
      end
      M_EXP: begin
        if (is_digit(c)) begin fl = inc; fm = M_EXPD; end
        else begin f_emit = 1'b1; f_kind = TK_DEC; f_err = ER_EXP; do_start = 1'b1; end
      end
      M_EXPD: begin
        if (is_digit(c)) fl = inc;
        else begin f_emit = 1'b1; f_kind = TK_DEC; do_start = 1'b1; end
      end
      default: do_start = 1'b1;
    endcase

    if (f_emit) begin
      fm = M_IDLE;
      fl = '0;
      fe = ER_NONE;
    end

    // the byte opens a new token
    if (do_start) begin
      fl = LenW'(1);
      fe = ER_NONE;
      fm = M_IDLE;
      s_emit = 1'b1;
      if (is_blank(c)) begin
        s_emit = 1'b0;
        fm = M_BLANK;
      end else begin
        case (c)
          CH_NL:     begin s_kind = TK_NL; bump = 1'b1; end
          CH_SLASH:  begin s_emit = 1'b0; fm = M_SLASH; end
          CH_PCT:    begin s_emit = 1'b0; fm = M_PCT; end
          CH_COLON:  begin s_emit = 1'b0; fm = M_COLON; end
          CH_BANG:   begin s_emit = 1'b0; fm = M_BANG; end
          CH_BAR:    begin s_emit = 1'b0; fm = M_BAR; end
          CH_SQUOTE: begin s_emit = 1'b0; fm = M_SQ; end
          CH_DQUOTE: begin s_emit = 1'b0; fm = M_DQ; end
          CH_EQ:     s_kind = TK_EQ;
          CH_COMMA:  s_kind = TK_COMMA;
          CH_SEMI:   s_kind = TK_SEMI;
          CH_PLUS:   s_kind = TK_PLUS;
          CH_MINUS:  s_kind = TK_MINUS;
          CH_STAR:   s_kind = TK_STAR;
          CH_QUEST:  s_kind = TK_QUEST;
          CH_LPAR:   s_kind = TK_LPAR;
          CH_RPAR:   s_kind = TK_RPAR;
          CH_LBRACE: s_kind = TK_LBRACE;
          CH_RBRACE: s_kind = TK_RBRACE;
          CH_DOT:    s_kind = TK_DOT;
          default: begin
            if (is_alpha(c)) begin s_emit = 1'b0; fm = M_IDENT; end
            else if (is_digit(c)) begin s_emit = 1'b0; fm = M_INT; end
            else begin s_kind = TK_ILLEGAL; s_err = ER_ILLEGAL; end
          end
        endcase
      end
      if (s_emit) fl = '0;
    end
  end

  assign line_b = (bump && line_r != LineMax) ? LineW'(line_r + 1'b1) : line_r;

  // end-of-input flush of what the byte left pending
  always_comb begin
    x_emit = in_tlast;
    x_kind = TK_BLANK;
    x_err  = ER_NONE;
    case (fm)
      M_BLANK:     x_kind = TK_BLANK;
      M_SLASH:     x_kind = TK_SLASH;
      M_BC, M_BC_STAR, M_PB, M_PB_PCT: begin x_kind = TK_BCMT; x_err = ER_UNTERM; end
      M_PCT, M_LINE: x_kind = TK_LCMT;
      M_COLON:     x_kind = TK_COLON;
      M_COLON_BAR: begin x_kind = TK_ILLEGAL; x_err = ER_REPEAT; end
      M_BANG:      begin x_kind = TK_ILLEGAL; x_err = ER_ILLEGAL; end
      M_BAR:       x_kind = TK_BAR;
      M_SQ, M_SQ_ESC: begin x_kind = TK_SQSTR; x_err = ER_UNTERM; end
      M_DQ, M_DQ_ESC: begin x_kind = TK_DQSTR; x_err = ER_UNTERM; end
      M_IDENT:     x_kind = TK_IDENT;
      M_INT:       x_kind = TK_INT;
      M_DOT:       begin x_kind = TK_DEC; x_err = ER_FRAC; end
      M_FRAC, M_EXPD: x_kind = TK_DEC;
      M_EXP:       begin x_kind = TK_DEC; x_err = ER_EXP; end
      default:     x_emit = 1'b0;
    endcase
  end

  always_comb begin
    rf = '{len: f_len, line: line_r, err: f_err, kind: f_kind, last: 1'b0};
    rs = '{len: LenW'(1), line: line_r, err: s_err, kind: s_kind, last: 1'b0};
    rx = '{len: fl, line: line_b, err: x_err, kind: x_kind, last: 1'b0};
    n1 = f_emit || s_emit || x_emit;
    n2 = (f_emit && (s_emit || x_emit)) || (s_emit && x_emit);
    r0 = f_emit ? rf : (s_emit ? rs : rx);
    r1 = (f_emit && s_emit) ? rs : rx;
    r0.last = !n2;
    r1.last = 1'b1;
  end

  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    err_nxt  = err_r;
    line_nxt = line_r;
    if (acc) begin
      line_nxt = line_b;
      mode_nxt = in_tlast ? M_IDLE : fm;
      len_nxt  = in_tlast ? '0 : fl;
      err_nxt  = in_tlast ? ER_NONE : fe;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (acc) count_nxt = 3'(count_nxt + {1'b0, n2, n1 && !n2});
    if (pop) count_nxt = 3'(count_nxt - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      line_r   <= LineW'(1);
      len_r    <= '0;
      err_r    <= ER_NONE;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      len_r   <= len_nxt;
      err_r   <= err_nxt;
      count_r <= count_nxt;
      if (pop) rd_ptr_r <= 2'(rd_ptr_r + 1'b1);
      if (acc && n1) wr_ptr_r <= 2'(wr_ptr_r + {n2, !n2});
    end
  end

  always_ff @(posedge clk) begin
    if (acc && n1) q_r[wr_ptr_r] <= r0;
    if (acc && n2) q_r[2'(wr_ptr_r + 1'b1)] <= r1;
  end

  assign in_tready  = (count_r <= 3'd2);
  assign out_tvalid = (count_r != 3'd0);
  assign out_tdata  = {4'b0, q_r[rd_ptr_r].len, q_r[rd_ptr_r].line,
                       q_r[rd_ptr_r].err, q_r[rd_ptr_r].kind};
  assign out_tlast  = q_r[rd_ptr_r].last;

endmodule

// ===== sv/stt_checker.sv =====
// Port-level checks for the score text tokenizer, bound to its top level.
module stt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);
  import stt_pkg::*;

  logic [KindW-1:0] kind;
  logic [ErrW-1:0]  err;

  assign kind = out_tdata[4:0];
  assign err  = out_tdata[7:5];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled token changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("token shown right after reset");

  a_kind_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (err == ER_ILLEGAL || err == ER_REPEAT) |-> kind == TK_ILLEGAL)
    else $error("illegal error on a legal token kind");

  a_num_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (err == ER_FRAC || err == ER_EXP) |-> kind == TK_DEC)
    else $error("number error on a non-decimal token");

  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:8] != 16'd0 && out_tdata[39:36] == 4'd0)
    else $error("bad line number or padding");

endmodule

bind score_text_tokenizer stt_checker u_stt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== test/tb_score_text_tokenizer.sv =====
// Testbench for score_text_tokenizer: random and directed character streams checked against a lexer model.
`timescale 1ns / 1ps

module tb_score_text_tokenizer;
  import stt_pkg::*;

  localparam int unsigned CycleLimit = 1_200_000;

  typedef struct {
    logic [7:0] code;
    logic       eoi;
    logic       quiet;
  } char_item_t;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [ErrW-1:0]  err;
    logic [LineW-1:0] line;
    logic [LenW-1:0]  len;
    logic             last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  score_text_tokenizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] char_code
    .in_tlast   (in_tlast),   // end_of_input
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [4:0] kind, [7:5] error, [23:8] line, [35:24] length
    .out_tlast  (out_tlast)   // last_of_run
  );

  always #5 clk = ~clk;

  char_item_t  char_q[$];
  token_t      token_q[$];
  logic        cur_quiet = 1'b0;
  int unsigned eoi_odds = 0;
  logic        tail_quiet = 1'b0;
  logic        in_took = 1'b0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int unsigned cycles = 0;
  int unsigned chars_sent = 0;
  int unsigned tokens_seen = 0;
  int unsigned bad_count = 0;
  logic [31:0] kinds_seen = '0;
  logic [7:0]  errs_seen = '0;

  // lexer model state
  mode_t            lx_mode = M_IDLE;
  logic [LineW-1:0] lx_line = 16'd1;
  logic [LenW-1:0]  lx_len = '0;
  logic [ErrW-1:0]  lx_err = ER_NONE;
  token_t           run_tok[2];
  int               run_n;

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR;
  endfunction

  task automatic lex_emit(input logic [KindW-1:0] k, input logic [ErrW-1:0] e);
    if (run_n < 2) begin
      run_tok[run_n].kind = k;
      run_tok[run_n].err  = e;
      run_tok[run_n].line = lx_line;
      run_tok[run_n].len  = lx_len;
      run_tok[run_n].last = 1'b0;
      run_n++;
    end
    lx_mode = M_IDLE;
    lx_len  = '0;
    lx_err  = ER_NONE;
  endtask

  task automatic lex_grow();
    if (lx_len != LenMax) lx_len = lx_len + 1'b1;
  endtask

  task automatic lex_newline();
    if (lx_line != LineMax) lx_line = lx_line + 1'b1;
  endtask

  task automatic lex_begin(input logic [7:0] c);
    lx_len = '0;
    lx_err = ER_NONE;
    lex_grow();
    if (is_space(c)) begin
      lx_mode = M_BLANK;
    end else begin
      case (c)
        CH_NL: begin
          lex_emit(TK_NL, ER_NONE);
          lex_newline();
        end
        CH_SLASH:  lx_mode = M_SLASH;
        CH_PCT:    lx_mode = M_PCT;
        CH_COLON:  lx_mode = M_COLON;
        CH_BANG:   lx_mode = M_BANG;
        CH_BAR:    lx_mode = M_BAR;
        CH_SQUOTE: lx_mode = M_SQ;
        CH_DQUOTE: lx_mode = M_DQ;
        CH_EQ:     lex_emit(TK_EQ, ER_NONE);
        CH_COMMA:  lex_emit(TK_COMMA, ER_NONE);
        CH_SEMI:   lex_emit(TK_SEMI, ER_NONE);
        CH_PLUS:   lex_emit(TK_PLUS, ER_NONE);
        CH_MINUS:  lex_emit(TK_MINUS, ER_NONE);
        CH_STAR:   lex_emit(TK_STAR, ER_NONE);
        CH_QUEST:  lex_emit(TK_QUEST, ER_NONE);
        CH_LPAR:   lex_emit(TK_LPAR, ER_NONE);
        CH_RPAR:   lex_emit(TK_RPAR, ER_NONE);
        CH_LBRACE: lex_emit(TK_LBRACE, ER_NONE);
        CH_RBRACE: lex_emit(TK_RBRACE, ER_NONE);
        CH_DOT:    lex_emit(TK_DOT, ER_NONE);
        default: begin
          if (is_letter(c)) lx_mode = M_IDENT;
          else if (is_num(c)) lx_mode = M_INT;
          else lex_emit(TK_ILLEGAL, ER_ILLEGAL);
        end
      endcase
    end
  endtask

  task automatic str_body(input logic [7:0] c, input logic [7:0] q,
                          input logic [KindW-1:0] k, input mode_t esc);
    lex_grow();
    if (c == q) lex_emit(k, lx_err);
    else if (c == CH_BSLASH) lx_mode = esc;
    else if (c == CH_NL) lex_newline();
  endtask

  task automatic str_esc(input logic [7:0] c, input logic [7:0] q,
                         input logic [KindW-1:0] k, input mode_t body, input mode_t esc);
    lx_mode = body;
    if (c inside {CH_DQUOTE, CH_BSLASH, CH_LON, CH_LOT}) begin
      lex_grow();
    end else begin
      lx_err = ER_ESCAPE;
      str_body(c, q, k, esc);
    end
  endtask

  task automatic lex_feed(input logic [7:0] c);
    case (lx_mode)
      M_BLANK: begin
        if (is_space(c)) lex_grow();
        else begin lex_emit(TK_BLANK, ER_NONE); lex_begin(c); end
      end
      M_SLASH: begin
        if (c == CH_STAR) begin lex_grow(); lx_mode = M_BC; end
        else begin lex_emit(TK_SLASH, ER_NONE); lex_begin(c); end
      end
      M_BC: begin
        lex_grow();
        if (c == CH_NL) lex_newline();
        else if (c == CH_STAR) lx_mode = M_BC_STAR;
      end
      M_BC_STAR: begin
        lex_grow();
        if (c == CH_SLASH) begin
          lex_emit(TK_BCMT, ER_NONE);
        end else if (c != CH_STAR) begin
          if (c == CH_NL) lex_newline();
          lx_mode = M_BC;
        end
      end
      M_PCT: begin
        if (c == CH_LBRACE) begin lex_grow(); lx_mode = M_PB; end
        else if (c == CH_NL) begin lex_emit(TK_LCMT, ER_NONE); lex_begin(c); end
        else begin lex_grow(); lx_mode = M_LINE; end
      end
      M_PB: begin
        lex_grow();
        if (c == CH_NL) lex_newline();
        else if (c == CH_PCT) lx_mode = M_PB_PCT;
      end
      M_PB_PCT: begin
        lex_grow();
        if (c == CH_RBRACE) begin
          lex_emit(TK_BCMT, ER_NONE);
        end else if (c != CH_PCT) begin
          if (c == CH_NL) lex_newline();
          lx_mode = M_PB;
        end
      end
      M_LINE: begin
        if (c == CH_NL) begin lex_emit(TK_LCMT, ER_NONE); lex_begin(c); end
        else lex_grow();
      end
      M_COLON: begin
        if (c == CH_BAR) begin lex_grow(); lx_mode = M_COLON_BAR; end
        else begin lex_emit(TK_COLON, ER_NONE); lex_begin(c); end
      end
      M_COLON_BAR: begin
        if (c == CH_BAR) begin lex_grow(); lex_emit(TK_REPEAT, ER_NONE); end
        else begin lex_emit(TK_ILLEGAL, ER_REPEAT); lex_begin(c); end
      end
      M_BANG: begin
        if (c == CH_BANG) begin lex_grow(); lex_emit(TK_BANG2, ER_NONE); end
        else begin lex_emit(TK_ILLEGAL, ER_ILLEGAL); lex_begin(c); end
      end
      M_BAR: begin
        if (c == CH_BAR) begin lex_grow(); lex_emit(TK_BAR2, ER_NONE); end
        else begin lex_emit(TK_BAR, ER_NONE); lex_begin(c); end
      end
      M_SQ:     str_body(c, CH_SQUOTE, TK_SQSTR, M_SQ_ESC);
      M_SQ_ESC: str_esc(c, CH_SQUOTE, TK_SQSTR, M_SQ, M_SQ_ESC);
      M_DQ:     str_body(c, CH_DQUOTE, TK_DQSTR, M_DQ_ESC);
      M_DQ_ESC: str_esc(c, CH_DQUOTE, TK_DQSTR, M_DQ, M_DQ_ESC);
      M_IDENT: begin
        if (is_letter(c) || is_num(c) || c == CH_UNDER) lex_grow();
        else begin lex_emit(TK_IDENT, ER_NONE); lex_begin(c); end
      end
      M_INT: begin
        if (is_num(c)) lex_grow();
        else if (c == CH_DOT) begin lex_grow(); lx_mode = M_DOT; end
        else if (c == CH_LOE || c == CH_UPE) begin lex_grow(); lx_mode = M_EXP; end
        else begin lex_emit(TK_INT, ER_NONE); lex_begin(c); end
      end
      M_DOT: begin
        if (is_num(c)) begin lex_grow(); lx_mode = M_FRAC; end
        else begin lex_emit(TK_DEC, ER_FRAC); lex_begin(c); end
      end
      M_FRAC: begin
        if (is_num(c)) lex_grow();
        else if (c == CH_LOE || c == CH_UPE) begin lex_grow(); lx_mode = M_EXP; end
        else begin lex_emit(TK_DEC, ER_NONE); lex_begin(c); end
      end
      M_EXP: begin
        if (is_num(c)) begin lex_grow(); lx_mode = M_EXPD; end
        else begin lex_emit(TK_DEC, ER_EXP); lex_begin(c); end
      end
      M_EXPD: begin
        if (is_num(c)) lex_grow();
        else begin lex_emit(TK_DEC, ER_NONE); lex_begin(c); end
      end
      default: lex_begin(c);
    endcase
  endtask

  task automatic lex_flush();
    case (lx_mode)
      M_BLANK:                          lex_emit(TK_BLANK, ER_NONE);
      M_SLASH:                          lex_emit(TK_SLASH, ER_NONE);
      M_BC, M_BC_STAR, M_PB, M_PB_PCT:  lex_emit(TK_BCMT, ER_UNTERM);
      M_PCT, M_LINE:                    lex_emit(TK_LCMT, ER_NONE);
      M_COLON:                          lex_emit(TK_COLON, ER_NONE);
      M_COLON_BAR:                      lex_emit(TK_ILLEGAL, ER_REPEAT);
      M_BANG:                           lex_emit(TK_ILLEGAL, ER_ILLEGAL);
      M_BAR:                            lex_emit(TK_BAR, ER_NONE);
      M_SQ, M_SQ_ESC:                   lex_emit(TK_SQSTR, ER_UNTERM);
      M_DQ, M_DQ_ESC:                   lex_emit(TK_DQSTR, ER_UNTERM);
      M_IDENT:                          lex_emit(TK_IDENT, ER_NONE);
      M_INT:                            lex_emit(TK_INT, ER_NONE);
      M_DOT:                            lex_emit(TK_DEC, ER_FRAC);
      M_FRAC, M_EXPD:                   lex_emit(TK_DEC, ER_NONE);
      M_EXP:                            lex_emit(TK_DEC, ER_EXP);
      default: begin
        lx_mode = M_IDLE;
        lx_len  = '0;
        lx_err  = ER_NONE;
      end
    endcase
  endtask

  // tokens caused by one accepted character, in order
  task automatic lex_char(input logic [7:0] c, input logic eoi);
    token_t t;
    run_n = 0;
    lex_feed(c);
    if (eoi) lex_flush();
    for (int i = 0; i < run_n; i++) begin
      t = run_tok[i];
      t.last = (i == run_n - 1);
      token_q.push_back(t);
    end
  endtask

  // stimulus helpers
  task automatic put(input logic [7:0] c);
    char_item_t it;
    it.code  = c;
    it.eoi   = (eoi_odds != 0) && ($urandom_range(1, eoi_odds) == 1);
    it.quiet = cur_quiet;
    char_q.push_back(it);
  endtask

  task automatic put_end(input logic [7:0] c);
    char_item_t it;
    it.code  = c;
    it.eoi   = 1'b1;
    it.quiet = cur_quiet;
    char_q.push_back(it);
  endtask

  task automatic put_s(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] rnd_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rnd_blank();
    case ($urandom_range(0, 2))
      0:       return CH_SP;
      1:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rnd_body();
    case ($urandom_range(0, 7))
      0:       return CH_STAR;
      1:       return CH_SLASH;
      2:       return CH_PCT;
      3:       return CH_RBRACE;
      4:       return CH_NL;
      5:       return pick("abcxyz ");
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic gen_token();
    int n;
    int form;
    logic [7:0] q;
    case ($urandom_range(0, 19))
      0: begin
        n = $urandom_range(1, 6);
        repeat (n) put(rnd_blank());
      end
      1: put(CH_NL);
      2: begin
        put_s("/*");
        n = $urandom_range(0, 12);
        repeat (n) put(rnd_body());
        if ($urandom_range(0, 9) != 0) put_s("*/");
      end
      3: begin
        put_s("%{");
        n = $urandom_range(0, 12);
        repeat (n) put(rnd_body());
        if ($urandom_range(0, 9) != 0) put_s("%}");
      end
      4: begin
        put(CH_PCT);
        n = $urandom_range(0, 10);
        repeat (n) put(pick("ab%{}* /x9"));
        put(CH_NL);
      end
      5, 6: put(pick("/=,;+-*?(){}."));
      7: begin
        form = $urandom_range(0, 2);
        put(CH_COLON);
        if (form > 0) put(CH_BAR);
        if (form == 1) put(CH_BAR);
      end
      8: begin
        put(CH_BANG);
        if ($urandom_range(0, 2) != 0) put(CH_BANG);
      end
      9: begin
        put(CH_BAR);
        if ($urandom_range(0, 1) != 0) put(CH_BAR);
      end
      10, 11: begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        put(q);
        n = $urandom_range(0, 8);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin
              put(CH_BSLASH);
              if ($urandom_range(0, 2) != 0) put(pick("\"\\nt"));
              else put(8'($urandom_range(0, 255)));
            end
            1:       put(CH_NL);
            2:       put(8'($urandom_range(0, 255)));
            default: put(pick("abc 19_"));
          endcase
        end
        if ($urandom_range(0, 9) != 0) put(q);
      end
      12, 13: begin
        put(pick("aZqEeXbm"));
        n = $urandom_range(0, 7);
        repeat (n) put(pick("azAZ09_e"));
      end
      14, 15: begin
        n = $urandom_range(1, 4);
        repeat (n) put(rnd_digit());
        form = $urandom_range(0, 5);
        if (form >= 1 && form <= 3) begin
          put(CH_DOT);
          if (form != 2) begin
            n = $urandom_range(1, 3);
            repeat (n) put(rnd_digit());
          end
        end
        if (form >= 3) begin
          put($urandom_range(0, 1) ? CH_LOE : CH_UPE);
          if (form != 5) begin
            n = $urandom_range(1, 3);
            repeat (n) put(rnd_digit());
          end
        end
      end
      16: put(8'($urandom_range(0, 255)));
      17: put($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 31)));
      18: put_end(rnd_body());
      default: put(pick("\\_@#$&^~`[]<>"));
    endcase
  endtask

  // input side: present pending characters at the falling edge
  always @(negedge clk) begin : tx_drive
    logic       v;
    logic [7:0] d;
    logic       l;
    char_item_t it;
    v = in_tvalid;
    d = in_tdata;
    l = in_tlast;
    if (rst_n) begin
      if (in_tvalid && in_took) v = 1'b0;
      if (!v) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (char_q.size() > 0) begin
          if (!char_q[0].quiet && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(0, 13);
          end else begin
            it = char_q.pop_front();
            v = 1'b1;
            d = it.code;
            l = it.eoi;
            tail_quiet = it.quiet;
          end
        end
      end
    end
    in_tvalid <= v;
    in_tdata  <= d;
    in_tlast  <= l;
  end

  // output side: random back-pressure bursts
  always @(negedge clk) begin : rx_pace
    if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic cmp(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: token %0d %s expected %0d, got %0d", $time, tokens_seen, what, want, got);
      bad_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    cycles++;
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took) begin
      chars_sent++;
      lex_char(in_tdata, in_tlast);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token, expected none, got kind %0d err %0d line %0d len %0d",
                 $time, out_tdata[4:0], out_tdata[7:5], out_tdata[23:8], out_tdata[35:24]);
        bad_count++;
      end else begin
        want = token_q.pop_front();
        cmp("kind", want.kind, out_tdata[4:0]);
        cmp("error", want.err, out_tdata[7:5]);
        cmp("line", want.line, out_tdata[23:8]);
        cmp("length", want.len, out_tdata[35:24]);
        cmp("pad", 0, out_tdata[39:36]);
        cmp("tlast", want.last, out_tlast);
        kinds_seen[want.kind] = 1'b1;
        errs_seen[want.err] = 1'b1;
      end
      tokens_seen++;
    end
  end

  initial begin : watchdog
    wait (cycles >= CycleLimit);
    $display("%0t: timeout, %0d characters left, %0d tokens outstanding",
             $time, char_q.size(), token_q.size());
    $display("score_text_tokenizer: mismatch");
    $finish;
  end

  initial begin : main
    int unsigned random_end;
    int unsigned seg;
    // directed: byte extremes, broken repeat, missing fraction and exponent
    // digits, bad escape, lone bang, unterminated string at end of input
    put(8'h00);
    put(8'hFF);
    put_s(":|x");
    put_s("1.;");
    put_s("2e+");
    put_s("'\\q'");
    put_s("!x");
    put_s("\"a");
    put_end(CH_LBRACE);

    eoi_odds = 150;
    random_end = char_q.size() + 1800;
    seg = 0;
    while (char_q.size() < random_end) begin
      if (char_q.size() >= seg) begin
        cur_quiet = ($urandom_range(0, 3) == 0);
        seg = char_q.size() + $urandom_range(60, 250);
      end
      gen_token();
    end

    // no idling from here on
    cur_quiet = 1'b1;
    eoi_odds = 40;
    repeat (30) gen_token();
    put_end(CH_SEMI);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_q.size() > 0 || in_tvalid) @(posedge clk);
    while (token_q.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Streamed %0d characters, checked %0d tokens, final line %0d.",
             chars_sent, tokens_seen, lx_line);
    $display("Token kinds covered: %0d of 28, error codes covered: %0d of 7.",
             $countones(kinds_seen), $countones(errs_seen));
    if (bad_count == 0 && token_q.size() == 0) begin
      $display("score_text_tokenizer: match");
    end else begin
      $display("%0t: %0d mismatches, %0d tokens never arrived", $time, bad_count, token_q.size());
      $display("score_text_tokenizer: mismatch");
    end
    $finish;
  end

endmodule
